// ===== src/sh13_pkg.sv =====
// shared types and constants of the siphash-1-3 keyed hash block
package sh13_pkg;

    // siphash initialization constants
    localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
    localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
    localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
    localparam logic [63:0] SIP_C3 = 64'h7465646279746573;

    // constant folded into mix_c before finalization
    localparam logic [63:0] FIN_XOR = 64'h00000000000000ff;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LOW   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_HIGH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FOLD_CASE = 2'd2;

    // stream widths
    localparam int unsigned WORD_W    = 64;
    localparam int unsigned COUNT_W   = 4;
    localparam int unsigned LEN_W     = 8;
    localparam int unsigned S_TDATA_W = 72;
    localparam int unsigned M_TDATA_W = 64;

    // number of finalization rounds
    localparam int unsigned FIN_ROUNDS = 3;

    // the four mixing words
    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
    } sh13_state_t;

    // prepared message material for one input item
    typedef struct packed {
        logic [WORD_W-1:0] word;   // whole word, case folded
        logic [WORD_W-1:0] block;  // final block: length byte and tail bytes
        logic [LEN_W-1:0]  len;    // updated length modulo 256
        logic              full;   // word is absorbed as eight bytes
    } sh13_prep_t;

endpackage

// ===== src/sh13_round.sv =====
// one siphash round with message injection around it
module sh13_round
    import sh13_pkg::*;
(
    input  sh13_state_t       v_in,
    input  logic [WORD_W-1:0] pre_xor,   // xored into mix_d before the round
    input  logic [WORD_W-1:0] post_xor,  // xored into mix_a after the round
    input  logic [WORD_W-1:0] c_xor,     // xored into mix_c after the round
    output sh13_state_t       v_out
);

    always_comb begin
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
        a = v_in.a;
        b = v_in.b;
        c = v_in.c;
        d = v_in.d ^ pre_xor;
        // first half
        a = a + b;
        b = {b[50:0], b[63:51]} ^ a;
        a = {a[31:0], a[63:32]};
        c = c + d;
        d = {d[47:0], d[63:48]} ^ c;
        // second half
        a = a + d;
        d = {d[42:0], d[63:43]} ^ a;
        c = c + b;
        b = {b[46:0], b[63:47]} ^ c;
        c = {c[31:0], c[63:32]};
        v_out.a = a ^ post_xor;
        v_out.b = b;
        v_out.c = c ^ c_xor;
        v_out.d = d;
    end

endmodule

// ===== src/sh13_prep.sv =====
// input item preparation: case folding, tail masking, final block and length
module sh13_prep
    import sh13_pkg::*;
(
    input  logic [WORD_W-1:0]  data_word,
    input  logic [COUNT_W-1:0] byte_count,
    input  logic               last,
    input  logic               fold_case,
    input  logic [LEN_W-1:0]   len_base,
    output sh13_prep_t         prep
);

    logic [COUNT_W-1:0] count_sat;
    logic [WORD_W-1:0]  folded;
    logic [WORD_W-1:0]  tail;
    logic [LEN_W-1:0]   len_add;

    // saturate the count to eight bytes
    assign count_sat = (byte_count > COUNT_W'(8)) ? COUNT_W'(8) : byte_count;

    // lowercase ascii letters byte by byte when fold_case is set, and mask bytes beyond the count
    always_comb begin
        logic [7:0] b;
        for (int i = 0; i < 8; i++) begin
            b = data_word[8*i +: 8];
            if (fold_case && (b inside {[8'h41:8'h5A]})) begin
                b = b | 8'h20;
            end
            folded[8*i +: 8] = b;
            tail[8*i +: 8]   = (COUNT_W'(i) < count_sat) ? b : 8'h00;
        end
    end

    always_comb begin
        prep.full = !last || (count_sat == COUNT_W'(8));
        len_add   = prep.full ? LEN_W'(8) : LEN_W'(count_sat);
        prep.len  = len_base + len_add;
        prep.word = folded;
        prep.block = {prep.len, (prep.full ? 56'd0 : tail[55:0])};
    end

endmodule

// ===== src/siphash13_keyed_hash.sv =====
// top level of the siphash-1-3 keyed hash: config registers, sequencer, result register
//
// Usage: a message enters on the s_ channel as little-endian 64-bit words,
// one per item, with tlast on the final word and the valid byte count of
// that word in tdata. Every word but the last counts as eight bytes. Each
// last word produces one 64-bit hash item on the m_ channel; other words
// produce nothing. The key and the case-folding mode are to be written on
// the cfg_wr_* port by the user while the block is idle, which the block
// itself does not enforce; the key is sampled at the first word of a message.
// Timing: one round unit does one siphash round per cycle, except while
// it holds in its last round for the output register. A word that is not
// last is accepted, then runs one word round. A last word is accepted, then
// runs the block round and three finalization rounds, with its own word round
// first when it holds eight bytes. s_tready is low while the rounds run.
// The hash sits in an output register; the next word is accepted while it
// waits. If the receiver stalls and a new hash is ready, the block holds
// in its last round until the output register frees up.
// Reset (aresetn low, synchronous) clears the key, the mode, any open
// message and the pending result.
module siphash13_keyed_hash
    import sh13_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // config write port
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [63:0]            cfg_wr_data,
    // input items
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // [63:0] data_word, [67:64] byte_count, rest zero
    input  logic                   s_tlast,
    // result items
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata    // [63:0] hash
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WORD,
        S_BLOCK,
        S_FIN
    } state_t;

    // control registers
    state_t             state_reg, state_next;
    logic               in_msg_reg, in_msg_next;
    logic               last_reg, last_next;
    logic [1:0]         fin_cnt_reg, fin_cnt_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               m_valid_reg, m_valid_next;
    logic [63:0]        key_low_reg, key_low_next;
    logic [63:0]        key_high_reg, key_high_next;
    logic               fold_reg, fold_next;
    // payload registers
    sh13_state_t        v_reg, v_next;
    logic [WORD_W-1:0]  word_reg, word_next;
    logic [WORD_W-1:0]  blk_reg, blk_next;
    logic [63:0]        hash_reg, hash_next;

    sh13_prep_t         prep;
    sh13_state_t        v_init;
    sh13_state_t        rnd_out;
    logic [WORD_W-1:0]  rnd_pre;
    logic [WORD_W-1:0]  rnd_post;
    logic [WORD_W-1:0]  rnd_cx;
    logic               accept;
    logic               out_free;
    logic [63:0]        hash_val;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = hash_reg;

    // item preparation
    sh13_prep u_prep (
        .data_word  (s_tdata[WORD_W-1:0]),
        .byte_count (s_tdata[WORD_W +: COUNT_W]),
        .last       (s_tlast),
        .fold_case  (fold_reg),
        .len_base   (in_msg_reg ? len_reg : LEN_W'(0)),
        .prep       (prep)
    );

    // shared round unit
    sh13_round u_round (
        .v_in     (v_reg),
        .pre_xor  (rnd_pre),
        .post_xor (rnd_post),
        .c_xor    (rnd_cx),
        .v_out    (rnd_out)
    );

    assign hash_val = rnd_out.a ^ rnd_out.b ^ rnd_out.c ^ rnd_out.d;

    // keyed start state
    always_comb begin
        v_init.a = key_low_reg ^ SIP_C0;
        v_init.b = key_high_reg ^ SIP_C1;
        v_init.c = key_low_reg ^ SIP_C2;
        v_init.d = key_high_reg ^ SIP_C3;
    end

    // round operand selection
    always_comb begin
        rnd_pre  = '0;
        rnd_post = '0;
        rnd_cx   = '0;
        case (state_reg)
            S_WORD: begin
                rnd_pre  = word_reg;
                rnd_post = word_reg;
            end
            S_BLOCK: begin
                rnd_pre  = blk_reg;
                rnd_post = blk_reg;
                rnd_cx   = FIN_XOR;
            end
            default: begin
                rnd_pre  = '0;
            end
        endcase
    end

    // sequencer and register next values
    always_comb begin
        state_next    = state_reg;
        in_msg_next   = in_msg_reg;
        last_next     = last_reg;
        fin_cnt_next  = fin_cnt_reg;
        len_next      = len_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        key_low_next  = key_low_reg;
        key_high_next = key_high_reg;
        fold_next     = fold_reg;
        v_next        = v_reg;
        word_next     = word_reg;
        blk_next      = blk_reg;
        hash_next     = hash_reg;

        // config writes
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_KEY_LOW:   key_low_next  = cfg_wr_data;
                CFG_KEY_HIGH:  key_high_next = cfg_wr_data;
                CFG_FOLD_CASE: fold_next     = cfg_wr_data[0];
                default:       fold_next     = fold_reg;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (!in_msg_reg) begin
                        v_next = v_init;
                    end
                    in_msg_next = !s_tlast;
                    last_next   = s_tlast;
                    len_next    = prep.len;
                    word_next   = prep.word;
                    blk_next    = prep.block;
                    state_next  = prep.full ? S_WORD : S_BLOCK;
                end
            end
            S_WORD: begin
                v_next     = rnd_out;
                state_next = last_reg ? S_BLOCK : S_IDLE;
            end
            S_BLOCK: begin
                v_next       = rnd_out;
                fin_cnt_next = '0;
                state_next   = S_FIN;
            end
            S_FIN: begin
                if (fin_cnt_reg == 2'(FIN_ROUNDS - 1)) begin
                    // last round: hold until the result register is free
                    if (out_free) begin
                        hash_next    = hash_val;
                        m_valid_next = 1'b1;
                        state_next   = S_IDLE;
                    end
                end else begin
                    v_next       = rnd_out;
                    fin_cnt_next = fin_cnt_reg + 2'd1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            in_msg_reg   <= 1'b0;
            last_reg     <= 1'b0;
            fin_cnt_reg  <= '0;
            len_reg      <= '0;
            m_valid_reg  <= 1'b0;
            key_low_reg  <= '0;
            key_high_reg <= '0;
            fold_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            in_msg_reg   <= in_msg_next;
            last_reg     <= last_next;
            fin_cnt_reg  <= fin_cnt_next;
            len_reg      <= len_next;
            m_valid_reg  <= m_valid_next;
            key_low_reg  <= key_low_next;
            key_high_reg <= key_high_next;
            fold_reg     <= fold_next;
            v_reg        <= v_next;
            word_reg     <= word_next;
            blk_reg      <= blk_next;
            hash_reg     <= hash_next;
        end
    end

endmodule
